@@ sv/dbam_pkg.sv @@
// ----------------------------------------------------------------------------
// dbam_pkg
// shared widths, command codes, types and arithmetic helpers of the
// double-buffered send mixer
// ----------------------------------------------------------------------------
package dbam_pkg;

    localparam int FRAMES_DEFAULT = 256;
    localparam int FRAME_W        = 8;
    localparam int FRAME_LIMIT    = 2 ** FRAME_W;
    localparam int SAMPLE_W       = 16;
    localparam int LEVEL_W        = 16;
    localparam int SUM_W          = 24;
    localparam int OPND_W         = SAMPLE_W + 1;
    localparam int PROD_W         = OPND_W + LEVEL_W + 1;
    localparam int CONTRIB_W      = 21;
    // left sum, right sum, frame valid flag on top
    localparam int WORD_W         = 2 * SUM_W + 1;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 2'd3;

    localparam logic [PROD_W:0] ROUND_HALF14 = (PROD_W + 1)'(1) << 13;
    localparam logic [PROD_W:0] ROUND_HALF15 = (PROD_W + 1)'(1) << 14;

    // operands for the two gain multipliers
    typedef struct packed {
        logic signed [OPND_W-1:0]  samp_a;
        logic signed [OPND_W-1:0]  samp_b;
        logic        [LEVEL_W-1:0] level;
        logic                      shift15;
    } gain_req_t;

    // scale by 2^-14 or 2^-15, round to nearest with ties toward plus infinity
    function automatic logic signed [CONTRIB_W-1:0] round_gain(
        input logic signed [PROD_W-1:0] p,
        input logic                     s15
    );
        logic [PROD_W:0]        t;
        logic signed [PROD_W:0] r;
        t = {p[PROD_W-1], p} + (s15 ? ROUND_HALF15 : ROUND_HALF14);
        r = s15 ? ($signed(t) >>> 15) : ($signed(t) >>> 14);
        return r[CONTRIB_W-1:0];
    endfunction

    // add and clamp to the signed 24 bit range
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]     a,
        input logic signed [CONTRIB_W-1:0] b
    );
        logic [SUM_W+1:0] s;
        s = {{2{a[SUM_W-1]}}, a}
            + {{(SUM_W + 2 - CONTRIB_W){b[CONTRIB_W-1]}}, b};
        if (s[SUM_W+1] == s[SUM_W] && s[SUM_W] == s[SUM_W-1]) begin
            return s[SUM_W-1:0];
        end else if (s[SUM_W+1]) begin
            return {1'b1, {(SUM_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(SUM_W - 1){1'b1}}};
        end
    endfunction

endpackage

@@ sv/double_buffered_audio_send_mixer.sv @@
// ----------------------------------------------------------------------------
// double_buffered_audio_send_mixer
// two mix buffers in one memory; accumulate scales a source frame by its
// send level and adds it into the current buffer with saturation
// ----------------------------------------------------------------------------
// timing: swap completes in the cycle it is accepted; accumulate writes back and
//   read presents its result after memory read and multiply, round, then add and
//   write back; a read facing a full output register waits
// flow: a swap leaves the input ready; accumulate (read-modify-write of one word), read
//   and begin_mix (clearing pass over the current buffer) hold s_tready low until done
// reset: buffer 1 current, bus stereo; a clearing pass empties both
module double_buffered_audio_send_mixer #(
    parameter int FRAMES = dbam_pkg::FRAMES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write: bus_is_stereo
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] frame_index, [23:8] sample_left, [39:24] sample_right,
    // [55:40] send_level
    input  logic [55:0] s_tdata,
    // [1:0] command, [2] source_is_stereo, [3] read_previous
    input  logic [3:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [23:0] out_left, [47:24] out_right
    output logic [47:0] m_tdata
);
    import dbam_pkg::*;

    // only frame_index values below 2^FRAME_W can ever be addressed
    localparam int FRAMES_EFF = (FRAMES < FRAME_LIMIT) ? FRAMES : FRAME_LIMIT;
    localparam int SLOTS      = 2 * FRAMES_EFF;
    localparam int SLOT_W     = $clog2(SLOTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    // input field unpacking
    logic [CMD_W-1:0]          in_cmd;
    logic [FRAME_W-1:0]        in_frame;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic                      in_src_st;
    logic [LEVEL_W-1:0]        in_level;
    logic                      in_rd_prev;

    assign in_frame   = s_tdata[7:0];
    assign in_left    = s_tdata[23:8];
    assign in_right   = s_tdata[39:24];
    assign in_level   = s_tdata[55:40];
    assign in_cmd     = s_tuser[1:0];
    assign in_src_st  = s_tuser[2];
    assign in_rd_prev = s_tuser[3];

    // control state
    logic [1:0]        state_reg, state_next;
    logic              bus_st_reg;
    logic              cur_buf_reg;
    // clearing pass: next slot to empty and last slot of the pass
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0] clr_last_reg, clr_last_next;

    // item captured at acceptance
    logic              is_read_reg;
    logic              src_st_reg;
    logic              in_range_reg;
    logic [SLOT_W-1:0] slot_reg;

    // output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic signed [SUM_W-1:0] out_left_reg, out_right_reg;

    logic                   in_acc;
    logic                   buf_sel;
    logic [FRAME_W+1:0]     slot_wide;
    logic [SLOT_W-1:0]      slot;
    logic                   in_range;
    logic                   needs_mem;
    gain_req_t              gain_req;
    logic signed [CONTRIB_W-1:0] contrib_a, contrib_b;
    logic [WORD_W-1:0]      rd_word;
    logic                   hit;
    logic signed [SUM_W-1:0] old_left, old_right;
    logic signed [SUM_W-1:0] new_left, new_right;
    logic signed [SUM_W-1:0] rd_left, rd_right;
    logic                   clearing;
    logic                   clr_done;
    logic                   mem_wr;
    logic [SLOT_W-1:0]      wr_addr;
    logic [WORD_W-1:0]      wr_word;
    logic                   out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;

    // slot address: buffer half plus frame; reads may target the previous buffer
    assign buf_sel   = (in_cmd == CMD_READ) ? (cur_buf_reg ^ in_rd_prev) : cur_buf_reg;
    assign slot_wide = (buf_sel ? (FRAME_W + 2)'(FRAMES_EFF) : '0) + (FRAME_W + 2)'(in_frame);
    assign slot      = slot_wide[SLOT_W-1:0];
    assign in_range  = {1'b0, in_frame} < (FRAME_W + 1)'(FRAMES_EFF);
    assign needs_mem = in_acc && (in_cmd == CMD_ACCUM || in_cmd == CMD_READ);

    // multiplier operands: stereo source into mono bus sums both channels,
    // mismatched channel counts scale by one more halving
    always_comb begin
        gain_req.samp_a = (!bus_st_reg && in_src_st)
                          ? (OPND_W'(in_left) + OPND_W'(in_right))
                          : OPND_W'(in_left);
        gain_req.samp_b  = OPND_W'(in_right);
        gain_req.level   = in_level;
        gain_req.shift15 = bus_st_reg ^ in_src_st;
    end

    dbam_gain u_gain (
        .aclk      (aclk),
        .en        (needs_mem),
        .req       (gain_req),
        .contrib_a (contrib_a),
        .contrib_b (contrib_b)
    );

    dbam_store #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (needs_mem),
        .rd_addr (slot),
        .rd_data (rd_word)
    );

    // frame with a cleared valid flag reads as zero
    assign hit       = in_range_reg && rd_word[WORD_W-1];
    assign old_left  = hit ? rd_word[SUM_W-1:0] : '0;
    assign old_right = hit ? rd_word[2*SUM_W-1:SUM_W] : '0;

    // accumulate; mono source on a stereo bus puts the same half on both sides
    always_comb begin
        new_left = sat_add(old_left, contrib_a);
        if (bus_st_reg) begin
            new_right = sat_add(old_right, src_st_reg ? contrib_b : contrib_a);
        end else begin
            new_right = '0;
        end
    end

    assign rd_left  = old_left;
    assign rd_right = bus_st_reg ? old_right : '0;

    assign out_load = (state_reg == ST_WRITE) && is_read_reg && (!m_tvalid_reg || m_tready);

    // write port: clearing pass writes empty words, accumulate writes a valid frame
    assign clearing = (state_reg == ST_CLEAR);
    assign clr_done = (clr_addr_reg == clr_last_reg);
    assign mem_wr   = clearing
                      || ((state_reg == ST_WRITE) && !is_read_reg && in_range_reg);
    assign wr_addr  = clearing ? clr_addr_reg : slot_reg;
    assign wr_word  = clearing ? '0 : {1'b1, new_right, new_left};

    // begin_mix walks the slots of the current buffer
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_last_next = clr_last_reg;
        if (in_acc && in_cmd == CMD_BEGIN) begin
            clr_addr_next = cur_buf_reg ? SLOT_W'(FRAMES_EFF) : '0;
            clr_last_next = cur_buf_reg ? SLOT_W'(SLOTS - 1) : SLOT_W'(FRAMES_EFF - 1);
        end else if (clearing) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_cmd == CMD_BEGIN) begin
                    state_next = ST_CLEAR;
                end else if (needs_mem) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                // a read waits here while the previous result is not taken
                if (!is_read_reg || out_load) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // empty both buffers before the first item
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_last_reg <= SLOT_W'(SLOTS - 1);
            bus_st_reg   <= 1'b1;
            cur_buf_reg  <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_last_reg <= clr_last_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                bus_st_reg <= cfg_data;
            end
            if (in_acc && in_cmd == CMD_SWAP) begin
                cur_buf_reg <= ~cur_buf_reg;
            end
        end
    end

    // item payload, held for the length of its processing
    always_ff @(posedge aclk) begin
        if (needs_mem) begin
            is_read_reg  <= (in_cmd == CMD_READ);
            src_st_reg   <= in_src_st;
            in_range_reg <= in_range;
            slot_reg     <= slot;
        end
        if (out_load) begin
            out_left_reg  <= rd_left;
            out_right_reg <= rd_right;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};

    // checks

    a_round_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |=> (state_reg == ST_WRITE))
        else $error("rounding stage not followed by write-back");

    a_mem_item_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        needs_mem |=> (state_reg == ST_ROUND))
        else $error("accumulate or read did not start processing");

    a_begin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && in_cmd == CMD_BEGIN) |=> (state_reg == ST_CLEAR))
        else $error("begin_mix did not start a clearing pass");

    a_clear_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (clearing && clr_done) |=> (state_reg == ST_IDLE))
        else $error("clearing pass ran past its last slot");

endmodule

@@ sv/dbam_store.sv @@
// ----------------------------------------------------------------------------
// dbam_store
// mix buffer memory, one frame (left and right sum plus valid flag) per word,
// one write port and one registered read port
// ----------------------------------------------------------------------------
module dbam_store #(
    parameter int SLOTS = 2 * dbam_pkg::FRAMES_DEFAULT,
    parameter int SLOT_W = $clog2(SLOTS)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [SLOT_W-1:0]          wr_addr,
    input  logic [dbam_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [SLOT_W-1:0]          rd_addr,
    output logic [dbam_pkg::WORD_W-1:0] rd_data
);
    import dbam_pkg::*;

    logic [WORD_W-1:0] mem [SLOTS];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/dbam_gain.sv @@
// ----------------------------------------------------------------------------
// dbam_gain
// two send-level multipliers followed by a rounding stage
// ----------------------------------------------------------------------------
module dbam_gain (
    input  logic                                  aclk,
    input  logic                                  en,
    input  dbam_pkg::gain_req_t                   req,
    output logic signed [dbam_pkg::CONTRIB_W-1:0] contrib_a,
    output logic signed [dbam_pkg::CONTRIB_W-1:0] contrib_b
);
    import dbam_pkg::*;

    logic signed [OPND_W-1:0]    level_s;
    logic signed [PROD_W-1:0]    prod_a_next;
    logic signed [PROD_W-1:0]    prod_b_next;
    logic signed [PROD_W-1:0]    prod_a_reg;
    logic signed [PROD_W-1:0]    prod_b_reg;
    logic                        shift15_reg;
    logic signed [CONTRIB_W-1:0] contrib_a_reg;
    logic signed [CONTRIB_W-1:0] contrib_b_reg;

    assign level_s     = {1'b0, req.level};
    assign prod_a_next = req.samp_a * level_s;
    assign prod_b_next = req.samp_b * level_s;

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_a_reg  <= prod_a_next;
            prod_b_reg  <= prod_b_next;
            shift15_reg <= req.shift15;
        end
    end

    // stage 2: scaled contributions
    always_ff @(posedge aclk) begin
        contrib_a_reg <= round_gain(prod_a_reg, shift15_reg);
        contrib_b_reg <= round_gain(prod_b_reg, shift15_reg);
    end

    assign contrib_a = contrib_a_reg;
    assign contrib_b = contrib_b_reg;

endmodule
